// File: src/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared widths, register codes, reset values and the saturation helper for
// the fractional feedback delay unit.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = 16;
    localparam int DELAY_DEPTH = 1 << ADDR_BITS;
    localparam int FRAC_BITS   = 8;
    localparam int POS_BITS    = ADDR_BITS + FRAC_BITS;
    localparam int GAIN_BITS   = 17;
    localparam int DELAY_BITS  = 24;
    localparam int CFG_BITS    = 24;
    localparam int MUL_BITS    = SAMPLE_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int MLT_BITS    = GAIN_BITS - 1;
    localparam int CNT_BITS    = $clog2(MLT_BITS + 1);

    localparam logic [DELAY_BITS-1:0] DELAY_RESET    = DELAY_BITS'(1228800);
    localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET = GAIN_BITS'(45875);
    localparam logic [GAIN_BITS-1:0]  MIX_RESET      = GAIN_BITS'(65536);

    typedef enum logic [1:0] {
        CFG_DELAY    = 2'd0,
        CFG_FEEDBACK = 2'd1,
        CFG_MIX      = 2'd2,
        CFG_BYPASS   = 2'd3
    } t_cfg_idx;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    function automatic t_sample sat_sample(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - SUM_BITS'(1);
        if (v > hi) begin
            return t_sample'(hi);
        end else if (v < lo) begin
            return t_sample'(lo);
        end
        return t_sample'(v);
    endfunction

endpackage

// File: src/ffd_ram.sv
// ----------------------------------------------------------------------------
// ffd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fractional_feedback_delay_unit.sv
// ----------------------------------------------------------------------------
// fractional_feedback_delay_unit
// Mono feedback delay with a linearly interpolated fractional read tap.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed input sample per word, m_axis one output
//   sample per word. The config port writes delay (Q16.8), feedback gain,
//   mix gain and bypass; write it only while the block is idle.
//   From accept to result an item passes two store reads, then three
//   products through one shared shift-add multiplier at one multiplier bit
//   per cycle (multipliers of 8, 16 and 16 bits); no new word is accepted
//   until the item is through. Bypassed items, and items whose read index
//   meets the write index, skip both and go straight to the done state.
//   After reset the block sweeps the whole delay store to zero, one entry
//   per cycle, with s_axis_tready low; config writes are taken meanwhile.
//   The result sits in an output register; while the receiver stalls the
//   next item is still accepted and computed, and waits at its end for the
//   register to free.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ffd_pkg::SAMPLE_BITS-1:0] s_axis_tdata,  // [23:0] in_sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ffd_pkg::SAMPLE_BITS-1:0] m_axis_tdata,  // [23:0] out_sample
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [ffd_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import ffd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_RD3, S_MUL, S_INTERP, S_MIX, S_FB, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_INTERP, PH_MIX, PH_FB
    } t_phase;

    t_state                      r_state, n_state;
    t_phase                      r_phase, n_phase;
    logic [ADDR_BITS-1:0]        r_clr, n_clr;
    logic [ADDR_BITS-1:0]        r_widx, n_widx;
    logic [ADDR_BITS-1:0]        r_ri, n_ri;
    logic [FRAC_BITS-1:0]        r_frac, n_frac;
    logic                        r_adv, n_adv;
    t_sample                     r_x, n_x;
    t_sample                     r_y, n_y;
    t_sample                     r_d1, n_d1;
    t_sample                     r_dly, n_dly;
    logic signed [MUL_BITS-1:0]  r_mcand, n_mcand;
    logic signed [MUL_BITS-1:0]  r_acc, n_acc;
    logic [MLT_BITS-1:0]         r_mult, n_mult;
    logic [CNT_BITS-1:0]         r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    t_sample                     r_out, n_out;
    logic [DELAY_BITS-1:0]       r_delay, n_delay;
    logic [GAIN_BITS-1:0]        r_fb, n_fb;
    logic [GAIN_BITS-1:0]        r_mix, n_mix;
    logic                        r_bypass, n_bypass;

    logic                        ram_we;
    logic [ADDR_BITS-1:0]        ram_waddr;
    t_sample                     ram_wdata;
    logic [ADDR_BITS-1:0]        ram_raddr;
    t_sample                     ram_rdata;

    ffd_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(DELAY_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        logic [POS_BITS-1:0]         pos;
        logic signed [MUL_BITS:0]    sum;
        logic signed [MUL_BITS-1:0]  prod;
        logic signed [MUL_BITS-1:0]  dsum;
        logic signed [SUM_BITS-1:0]  tot;

        n_state     = r_state;
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_widx      = r_widx;
        n_ri        = r_ri;
        n_frac      = r_frac;
        n_adv       = r_adv;
        n_x         = r_x;
        n_y         = r_y;
        n_d1        = r_d1;
        n_dly       = r_dly;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_mult      = r_mult;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_delay     = r_delay;
        n_fb        = r_fb;
        n_mix       = r_mix;
        n_bypass    = r_bypass;

        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = '0;
        ram_raddr = r_ri;

        pos  = {r_widx, FRAC_BITS'(0)} - POS_BITS'(r_delay);
        sum  = '0;
        prod = '0;
        dsum = '0;
        tot  = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DELAY:    n_delay  = i_cfg_data[DELAY_BITS-1:0];
                CFG_FEEDBACK: n_fb     = i_cfg_data[GAIN_BITS-1:0];
                CFG_MIX:      n_mix    = i_cfg_data[GAIN_BITS-1:0];
                CFG_BYPASS:   n_bypass = i_cfg_data[0];
                default:      ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + ADDR_BITS'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_x    = t_sample'(s_axis_tdata);
                    n_y    = t_sample'(s_axis_tdata);
                    n_ri   = pos[POS_BITS-1:FRAC_BITS];
                    n_frac = pos[FRAC_BITS-1:0];
                    n_adv  = !r_bypass;
                    if (r_bypass || pos[POS_BITS-1:FRAC_BITS] == r_widx) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD1;
                    end
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                ram_raddr = r_ri + ADDR_BITS'(1);
                n_d1      = ram_rdata;
                n_state   = S_RD3;
            end
            S_RD3: begin
                n_mcand = MUL_BITS'(ram_rdata) - MUL_BITS'(r_d1);
                n_acc   = '0;
                n_mult  = MLT_BITS'(r_frac);
                n_cnt   = CNT_BITS'(FRAC_BITS);
                n_phase = PH_INTERP;
                n_state = S_MUL;
            end
            S_MUL: begin
                sum    = {r_acc[MUL_BITS-1], r_acc}
                       + (r_mult[0] ? {r_mcand[MUL_BITS-1], r_mcand} : '0);
                n_acc  = sum[MUL_BITS:1];
                n_mult = r_mult >> 1;
                n_cnt  = r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    unique case (r_phase)
                        PH_INTERP: n_state = S_INTERP;
                        PH_MIX:    n_state = S_MIX;
                        PH_FB:     n_state = S_FB;
                        default:   n_state = S_INTERP;
                    endcase
                end
            end
            S_INTERP: begin
                dsum    = MUL_BITS'(r_d1) + r_acc;
                n_dly   = t_sample'(dsum);
                n_mcand = MUL_BITS'(t_sample'(dsum)) - MUL_BITS'(r_x);
                n_acc   = '0;
                n_mult  = r_mix[MLT_BITS-1:0];
                n_cnt   = CNT_BITS'(MLT_BITS);
                n_phase = PH_MIX;
                n_state = S_MUL;
            end
            S_MIX: begin
                prod    = r_mix[GAIN_BITS-1] ? r_mcand : r_acc;
                tot     = SUM_BITS'(r_x) + SUM_BITS'(prod);
                n_y     = sat_sample(tot);
                n_mcand = MUL_BITS'(r_dly);
                n_acc   = '0;
                n_mult  = r_fb[MLT_BITS-1:0];
                n_cnt   = CNT_BITS'(MLT_BITS);
                n_phase = PH_FB;
                n_state = S_MUL;
            end
            S_FB: begin
                prod      = r_fb[GAIN_BITS-1] ? r_mcand : r_acc;
                tot       = SUM_BITS'(r_x) + SUM_BITS'(prod);
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                ram_wdata = sat_sample(tot);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_y;
                    n_out_valid = 1'b1;
                    if (r_adv) begin
                        n_widx = r_widx + ADDR_BITS'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_INTERP;
            r_clr       <= '0;
            r_widx      <= '0;
            r_adv       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_delay     <= DELAY_RESET;
            r_fb        <= FEEDBACK_RESET;
            r_mix       <= MIX_RESET;
            r_bypass    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_widx      <= n_widx;
            r_adv       <= n_adv;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_delay     <= n_delay;
            r_fb        <= n_fb;
            r_mix       <= n_mix;
            r_bypass    <= n_bypass;
        end
        r_ri    <= n_ri;
        r_frac  <= n_frac;
        r_x     <= n_x;
        r_y     <= n_y;
        r_d1    <= n_d1;
        r_dly   <= n_dly;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
        r_mult  <= n_mult;
        r_out   <= n_out;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// File: verif/ffd_echo_checker.sv
// ----------------------------------------------------------------------------
// ffd_echo_checker
// Watches the sample streams and the config port of the fractional feedback
// delay unit. It keeps its own copy of the delay line and registers, computes
// each output sample from every accepted input word, and compares the output
// words in order. It reports the count of outstanding words and mismatches.
// ----------------------------------------------------------------------------
module ffd_echo_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [ffd_pkg::SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] in_sample
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ffd_pkg::SAMPLE_BITS-1:0] m_axis_tdata,   // [23:0] out_sample
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [ffd_pkg::CFG_BITS-1:0]    i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import ffd_pkg::*;

    localparam longint GAIN_UNITY = 65536;
    localparam int     GAIN_SHIFT = 16;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

    t_sample               echo_line [DELAY_DEPTH];
    logic [ADDR_BITS-1:0]  head_idx;
    logic [DELAY_BITS-1:0] tap_q8;
    logic [GAIN_BITS-1:0]  fb_gain;
    logic [GAIN_BITS-1:0]  wet_gain;
    logic                  pass_thru;
    t_sample               echo_due [$];
    t_sample               due_word;
    int                    words_out;
    int                    bad_words;

    function automatic longint clip_sample(longint v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_MAX;
        end else if (v < SAMPLE_MIN) begin
            return SAMPLE_MIN;
        end
        return v;
    endfunction

    function automatic longint unity_clamp(logic [GAIN_BITS-1:0] g);
        return (longint'(g) > GAIN_UNITY) ? GAIN_UNITY : longint'(g);
    endfunction

    // compute one output sample and advance the line state
    function automatic t_sample echo_sample(t_sample x_in);
        logic [POS_BITS-1:0]  tap_pos;
        logic [ADDR_BITS-1:0] rd_idx;
        logic [ADDR_BITS-1:0] rd_next;
        longint               x;
        longint               d1;
        longint               d2;
        longint               frac;
        longint               delayed;
        longint               y;
        if (pass_thru) begin
            return x_in;
        end
        x       = longint'(x_in);
        y       = x;
        tap_pos = {head_idx, {FRAC_BITS{1'b0}}} - tap_q8;
        rd_idx  = tap_pos[POS_BITS-1:FRAC_BITS];
        rd_next = rd_idx + 1'b1;
        frac    = longint'(tap_pos[FRAC_BITS-1:0]);
        if (rd_idx != head_idx) begin
            d1      = echo_line[rd_idx];
            d2      = echo_line[rd_next];
            delayed = d1 + ((frac * (d2 - d1)) >>> FRAC_BITS);
            y       = clip_sample(x + ((unity_clamp(wet_gain) * (delayed - x)) >>> GAIN_SHIFT));
            echo_line[head_idx] =
                t_sample'(clip_sample(x + ((unity_clamp(fb_gain) * delayed) >>> GAIN_SHIFT)));
        end
        head_idx = head_idx + 1'b1;
        return t_sample'(y);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (echo_line[i]) echo_line[i] = '0;
            head_idx  = '0;
            tap_q8    = DELAY_RESET;
            fb_gain   = FEEDBACK_RESET;
            wet_gain  = MIX_RESET;
            pass_thru = 1'b0;
            echo_due.delete();
            words_out = 0;
            bad_words = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DELAY:    tap_q8    = i_cfg_data[DELAY_BITS-1:0];
                    CFG_FEEDBACK: fb_gain   = i_cfg_data[GAIN_BITS-1:0];
                    CFG_MIX:      wet_gain  = i_cfg_data[GAIN_BITS-1:0];
                    CFG_BYPASS:   pass_thru = i_cfg_data[0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                echo_due.push_back(echo_sample(t_sample'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (echo_due.size() == 0) begin
                    if (bad_words < 10) begin
                        $display("unexpected output word %0d: actual %h", words_out,
                                 m_axis_tdata);
                    end
                    bad_words++;
                end else begin
                    due_word = echo_due.pop_front();
                    if (due_word !== m_axis_tdata) begin
                        if (bad_words < 10) begin
                            $display("mismatch at output word %0d: expected %h actual %h",
                                     words_out, due_word, m_axis_tdata);
                        end
                        bad_words++;
                    end
                end
                words_out++;
            end
        end
        o_pending    <= echo_due.size();
        o_mismatches <= bad_words;
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the fractional feedback delay unit. A directed
// pass covers sample extremes, gains at and above unity, zero and wrapped
// delays, taps that meet the write point, and bypass; random register
// settings and samples follow, with bursts of idling on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffd_pkg::*;

    localparam t_sample SAMPLE_HI    = 24'h7FFFFF;
    localparam t_sample SAMPLE_LO    = 24'h800000;
    localparam int      RANDOM_UNTIL = 790;
    localparam int      CALM_WORDS   = 60;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_BITS-1:0] s_axis_tdata  = '0;   // [23:0] in_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [SAMPLE_BITS-1:0] m_axis_tdata;         // [23:0] out_sample
    logic                   i_cfg_we      = 1'b0;
    logic [1:0]             i_cfg_idx     = CFG_DELAY;
    logic [CFG_BITS-1:0]    i_cfg_data    = '0;

    int      pending;
    int      mismatches;
    bit      gaps_on   = 1'b1;
    bit      stalls_on = 1'b1;
    t_sample sample_q [$];
    int      words_sent;
    int      settings_seen;
    int      phase_len;

    fractional_feedback_delay_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    ffd_echo_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stall the output stream in bursts
    always begin
        @(posedge i_clk);
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_setting(logic [DELAY_BITS-1:0] dly, logic [GAIN_BITS-1:0] fb,
                                 logic [GAIN_BITS-1:0] mx, logic byp);
        cfg_write(CFG_DELAY, CFG_BITS'(dly));
        cfg_write(CFG_FEEDBACK, CFG_BITS'(fb));
        cfg_write(CFG_MIX, CFG_BITS'(mx));
        cfg_write(CFG_BYPASS, CFG_BITS'(byp));
        settings_seen++;
    endtask

    // drain the sample queue onto the input stream
    task automatic send_all();
        @(posedge i_clk);
        while (sample_q.size() > 0) begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= sample_q.pop_front();
            do @(posedge i_clk); while (!s_axis_tready);
            words_sent++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            2:       return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_BITS'(65536);
            2:       return GAIN_BITS'($urandom_range(65537, 131071));
            default: return GAIN_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_setting(bit allow_bypass);
        logic [DELAY_BITS-1:0] dly;
        logic                  byp;
        case ($urandom_range(0, 11))
            0:       dly = '0;
            1:       dly = '1;
            2:       dly = DELAY_BITS'($urandom());
            3:       dly = {16'($urandom_range(16'hFFF0, 16'hFFFF)), 8'($urandom())};
            default: dly = {16'($urandom_range(1, 24)), 8'($urandom())};
        endcase
        byp = allow_bypass && ($urandom_range(0, 7) == 0);
        apply_setting(dly, pick_gain(), pick_gain(), byp);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short integer tap, full feedback drives the line into saturation
        apply_setting(24'h000200, 17'h10000, 17'h08000, 1'b0);
        sample_q.push_back(SAMPLE_HI);
        sample_q.push_back(SAMPLE_LO);
        sample_q.push_back(SAMPLE_HI);
        sample_q.push_back(t_sample'(-1));
        sample_q.push_back(t_sample'(0));
        sample_q.push_back(t_sample'(1));
        send_all();
        wait_idle();

        // fractional tap, both gains above unity
        apply_setting(24'h000180, 17'h1FFFF, 17'h1FFFF, 1'b0);
        sample_q.push_back(SAMPLE_LO);
        sample_q.push_back(SAMPLE_LO);
        sample_q.push_back(SAMPLE_HI);
        sample_q.push_back(t_sample'(24'h5A5A5A));
        send_all();
        wait_idle();

        // zero delay: tap meets the write point
        apply_setting(24'h000000, 17'h0C000, 17'h10000, 1'b0);
        sample_q.push_back(t_sample'(24'hA5A5A5));
        sample_q.push_back(SAMPLE_HI);
        sample_q.push_back(SAMPLE_LO);
        send_all();
        wait_idle();

        // wrapped delays: one lands on the write point, one reads ahead
        apply_setting(24'hFFFFFF, 17'h10000, 17'h10000, 1'b0);
        sample_q.push_back(t_sample'(24'h123456));
        sample_q.push_back(t_sample'(24'hEDCBA9));
        send_all();
        wait_idle();
        apply_setting(24'hFFFF00, 17'h08000, 17'h10000, 1'b0);
        sample_q.push_back(t_sample'(24'h333333));
        sample_q.push_back(t_sample'(24'hCCCCCC));
        send_all();
        wait_idle();

        // bypass holds the line, then dry-only output from a near tap
        apply_setting(24'h000100, 17'h10000, 17'h10000, 1'b1);
        sample_q.push_back(SAMPLE_HI);
        sample_q.push_back(SAMPLE_LO);
        sample_q.push_back(t_sample'(24'h0F0F0F));
        send_all();
        wait_idle();
        apply_setting(24'h0000FF, 17'h00000, 17'h00000, 1'b0);
        sample_q.push_back(t_sample'(24'h400000));
        sample_q.push_back(t_sample'(24'hC00000));
        sample_q.push_back(t_sample'(24'h000001));
        send_all();
        wait_idle();

        while (words_sent < RANDOM_UNTIL) begin
            random_setting(1'b1);
            phase_len = $urandom_range(20, 70);
            repeat (phase_len) sample_q.push_back(pick_sample());
            send_all();
            wait_idle();
        end

        // calm tail: no idling on either stream
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_setting(1'b0);
        repeat (CALM_WORDS) sample_q.push_back(pick_sample());
        send_all();
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d samples over %0d register settings, with bypass and tap wrap",
                 words_sent, settings_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d output words outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/ffd_pkg.sv
src/ffd_ram.sv
src/fractional_feedback_delay_unit.sv
verif/ffd_echo_checker.sv
verif/tb.sv
